@@ hdl/integer_to_ascii_radix_core_assert.svh @@
// Assertion macros shared by the conversion core.
`ifndef INTEGER_TO_ASCII_RADIX_CORE_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property once reset has been released.
`define I2A_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("i2a check failed");

// Check a property at every edge, reset included.
`define I2A_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("i2a check failed");

`else

`define I2A_ASSERT(lbl, clk, rst_n, prop)
`define I2A_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ hdl/i2a_pkg.sv @@
package i2a_pkg;

  // Width of the value that is converted; the value field itself is VALUE_W wide.
  localparam int unsigned VALUE_BITS  = 64;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned RADIX_W     = 5;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned DIGIT_DEPTH = 64;
  localparam int unsigned DIGIT_AW    = $clog2(DIGIT_DEPTH);
  localparam int unsigned CNT_W       = DIGIT_AW + 1;
  localparam int unsigned STEP_W      = $clog2(VALUE_BITS);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);
  localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

  localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [RADIX_W-1:0]    radix;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    return DIGIT_CHARS[d];
  endfunction

endpackage

@@ hdl/i2a_in_if.sv @@
interface i2a_in_if import i2a_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [RADIX_W-1:0] radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

@@ hdl/i2a_out_if.sv @@
interface i2a_out_if import i2a_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

@@ hdl/i2a_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle, small radix divisor.
module i2a_div import i2a_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  div_ctrl_t             ctrl_i,
  output div_stat_t             stat_o,
  output logic [VALUE_BITS-1:0] quot_o,
  output logic [DIGIT_W-1:0]    rem_o
);

  logic                  busy_q;
  logic                  done_q;
  logic [STEP_W-1:0]     step_q;
  logic [VALUE_BITS-1:0] quot_q;
  logic [DIGIT_W-1:0]    rem_q;
  logic [RADIX_W-1:0]    rad_q;

  logic [RADIX_W-1:0] trial;
  logic [RADIX_W-1:0] diff;
  logic               fits;

  // Bring down the next dividend bit and try the subtraction.
  assign trial = {rem_q, quot_q[VALUE_BITS-1]};
  assign fits  = (trial >= rad_q);
  assign diff  = trial - rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == STEP_W'(VALUE_BITS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      quot_q <= ctrl_i.dividend;
      rem_q  <= '0;
      rad_q  <= ctrl_i.radix;
    end else if (busy_q) begin
      quot_q <= {quot_q[VALUE_BITS-2:0], fits};
      rem_q  <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;
  assign rem_o       = rem_q;

endmodule

@@ hdl/integer_to_ascii_radix_core.sv @@
// Integer to ASCII conversion in radix 2 to 16. Each input word carries a value
// and a radix; the core returns one output word per character, most significant
// digit first, with last set on the final one. Radix 10 reads the value as
// signed and leads a negative with '-'; any other radix prints the two's
// complement pattern as unsigned. Radix codes below 2 act as 2, above 16 as 16.
// Digits are found by repeated bit-serial division of the magnitude by the
// radix, one quotient bit per cycle; each remainder is written to the digit
// memory, and characters are read back through its registered read port, a
// leading sign first. One item is converted at a time; the next input word can
// be taken in the cycle after the last character is loaded into the output
// register.
`include "integer_to_ascii_radix_core_assert.svh"

module integer_to_ascii_radix_core import i2a_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  i2a_in_if.sink    in_i,
  i2a_out_if.source out_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_SEND = 3'd4;

  logic [2:0] state_q, state_d;

  // Conversion context.
  logic [CNT_W-1:0]    cnt_q;     // digits written so far
  logic [DIGIT_AW-1:0] rd_idx_q;  // next digit to send, counting down
  logic                neg_q;
  logic [RADIX_W-1:0]  rad_q;

  // Digit memory, least significant digit at index zero.
  logic [DIGIT_W-1:0] dig_mem [DIGIT_DEPTH];
  logic [DIGIT_W-1:0] rd_data_q;

  // Output register.
  logic              out_valid_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_last_q;

  logic                  in_ready;
  logic                  in_acc;
  logic [RADIX_W-1:0]    rad_in;
  logic [VALUE_BITS-1:0] val_in;
  logic                  neg_in;
  logic [VALUE_BITS-1:0] mag_in;

  div_ctrl_t             div_ctrl;
  div_stat_t             div_stat;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;
  logic                  div_last;
  logic                  digit_done;

  logic out_free;
  logic out_load;

  // Accept a new word only between conversions.
  assign in_ready   = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // Clamp the radix into its legal range.
  always_comb begin
    if (in_i.radix < RADIX_MIN) begin
      rad_in = RADIX_MIN;
    end else if (in_i.radix > RADIX_MAX) begin
      rad_in = RADIX_MAX;
    end else begin
      rad_in = in_i.radix;
    end
  end

  // Decimal takes the magnitude of a signed value; the most negative value
  // negates onto itself, which read unsigned is the right magnitude.
  assign val_in = in_i.value[VALUE_BITS-1:0];
  assign neg_in = (rad_in == RADIX_DEC) && val_in[VALUE_BITS-1];
  assign mag_in = neg_in ? (~val_in + VALUE_BITS'(1)) : val_in;

  // Stop dividing once the quotient is spent or the memory is full.
  assign digit_done = (state_q == S_DIV) && div_stat.done;
  assign div_last   = (div_quot == '0) || (cnt_q == CNT_W'(DIGIT_DEPTH - 1));

  always_comb begin
    div_ctrl.start    = in_acc || (digit_done && !div_last);
    div_ctrl.dividend = in_acc ? mag_in : div_quot;
    div_ctrl.radix    = in_acc ? rad_in : rad_q;
  end

  i2a_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .stat_o (div_stat),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign out_load = out_free && ((state_q == S_SIGN) || (state_q == S_SEND));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_DIV;
      end
      S_DIV: begin
        if (digit_done && div_last) state_d = neg_q ? S_SIGN : S_READ;
      end
      S_SIGN: begin
        if (out_free) state_d = S_READ;
      end
      S_READ: begin
        state_d = S_SEND;
      end
      S_SEND: begin
        if (out_free) state_d = (rd_idx_q == '0) ? S_IDLE : S_READ;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        cnt_q <= '0;
      end else if (digit_done) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      // Start reading from the digit just written, then walk down.
      if (digit_done && div_last) begin
        rd_idx_q <= cnt_q[DIGIT_AW-1:0];
      end else if ((state_q == S_SEND) && out_free && (rd_idx_q != '0)) begin
        rd_idx_q <= rd_idx_q - DIGIT_AW'(1);
      end
      if (out_free) begin
        out_valid_q <= out_load;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      neg_q <= neg_in;
      rad_q <= rad_in;
    end
    if (out_load) begin
      out_char_q <= (state_q == S_SIGN) ? CHAR_MINUS : digit_char(rd_data_q);
      out_last_q <= (state_q == S_SEND) && (rd_idx_q == '0);
    end
  end

  // Digit memory: write the remainder of each division, registered read.
  always_ff @(posedge clk_i) begin
    if (digit_done) begin
      dig_mem[cnt_q[DIGIT_AW-1:0]] <= div_rem;
    end
    if (state_q == S_READ) begin
      rd_data_q <= dig_mem[rd_idx_q];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.character = out_char_q;
  assign out_o.last      = out_last_q;

  `I2A_ASSERT(a_accept_starts_div, clk_i, rst_ni, in_acc |=> (state_q == S_DIV))
  `I2A_ASSERT(a_div_done_in_div, clk_i, rst_ni, div_stat.done |-> (state_q == S_DIV))
  `I2A_ASSERT(a_cnt_in_range, clk_i, rst_ni, (cnt_q <= CNT_W'(DIGIT_DEPTH)))
  `I2A_ASSERT_ALWAYS(a_idle_div_quiet, clk_i, (state_q == S_IDLE) |-> !div_stat.busy)

endmodule
